FILE: hw/rtl/stereo_chorus_delay_defines.svh
// Assertion macros for the stereo chorus delay block.
`ifndef STEREO_CHORUS_DELAY_DEFINES_SVH
`define STEREO_CHORUS_DELAY_DEFINES_SVH
`ifndef SYNTHESIS
`define SCD_ASSERT_IMPL(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
`define SCD_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`else
`define SCD_ASSERT_IMPL(label, clk, rst_n, prop)
`define SCD_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

FILE: hw/rtl/scd_pkg.sv
// ----------------------------------------------------------------------------
// scd_pkg
// Shared constants and helpers of the stereo chorus delay.
// ----------------------------------------------------------------------------
`default_nettype none
package scd_pkg;
	localparam int LINE_DEPTH  = 8192;
	localparam int AW          = $clog2(LINE_DEPTH);
	localparam int SAMPLE_BITS = 24;

	localparam logic [2:0] REG_RATE  = 3'd0;
	localparam logic [2:0] REG_DEPTH = 3'd1;
	localparam logic [2:0] REG_BASE  = 3'd2;
	localparam logic [2:0] REG_FB    = 3'd3;
	localparam logic [2:0] REG_LEVEL = 3'd4;
	localparam logic [2:0] REG_REV   = 3'd5;
	localparam logic [2:0] REG_DLY   = 3'd6;
	localparam logic [2:0] REG_LPF   = 3'd7;

	localparam logic signed [SAMPLE_BITS-1:0] SAT_HI = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SAT_LO = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	// Saturate a wide signed value (already floor shifted) to a sample.
	function automatic logic signed [SAMPLE_BITS-1:0] sat48(input logic signed [47:0] v);
		if (v > 48'(SAT_HI))
			return SAT_HI;
		else if (v < 48'(SAT_LO))
			return SAT_LO;
		else
			return v[SAMPLE_BITS-1:0];
	endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/stereo_chorus_delay.sv
// ----------------------------------------------------------------------------
// stereo_chorus_delay
// Stereo chorus: triangle LFO, two interpolated taps, feedback delay lines.
// ----------------------------------------------------------------------------
// One mono word enters on s_axis (tdata = sample_in). One result word leaves
// on m_axis (tdata = wet_left, wet_right, reverb_send, delay_send from bit 0).
// The user must write registers on cfg (cfg_index, cfg_data) while the block
// is idle; the block itself does not enforce it. Each sample is processed by a
// sequencer around two single port line RAMs. Each line sees two reads and
// one write per sample. The result word is valid once the sequencer has
// stepped from LPF through DONE after the sample is accepted, and only then
// does it return to idle to take a new word. The result sits in an output
// register, so a new word is accepted while the previous result still waits.
// If that result has still not been taken when the next one is ready, the
// sequencer holds at its last step and the input stalls until the receiver
// takes the waiting word. After reset the block clears all 8192 entries of
// both delay lines, one entry per cycle; no word is accepted during that
// pass. Registers are taken at any time.
// ----------------------------------------------------------------------------
`default_nettype none
`include "stereo_chorus_delay_defines.svh"
module stereo_chorus_delay import scd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,   // [23:0] sample_in
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [95:0]      m_axis_tdata,   // wet_left, wet_right, reverb_send, delay_send
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	localparam int SW = 5;
	localparam logic [SW-1:0] ST_CLR = 5'd0, ST_IDLE = 5'd1, ST_LPF = 5'd2, ST_TAP = 5'd3,
		ST_RA0 = 5'd4, ST_RA1 = 5'd5, ST_RB0 = 5'd6, ST_RB1 = 5'd7, ST_RB2 = 5'd8,
		ST_MAC = 5'd9, ST_FB = 5'd10, ST_WR = 5'd11, ST_OUT1 = 5'd12, ST_OUT2 = 5'd13,
		ST_DONE = 5'd14;

	logic [SW-1:0] st_q;
	logic [AW-1:0] clr_q, wp_q;
	logic [23:0] phase_q;
	logic signed [23:0] lps_q, x_q;
	logic [15:0] rate_q, fb_q;
	logic [11:0] depth_q, base_q;
	logic [16:0] level_q, rev_q, dly_q, lpf_q;

	logic [AW-1:0] xl0_q, xr0_q;
	logic [7:0] fl_q, fr_q;
	logic signed [23:0] r0_q;
	logic signed [24:0] tl_q, tr_q;
	logic signed [23:0] wl_q, wr_q;
	logic [95:0] out_q;
	logic out_v_q;

	logic ram_we;
	logic [AW-1:0] ram_addr_l, ram_addr_r;
	logic signed [23:0] wdl, wdr, rdl, rdr;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= '0; depth_q <= '0; base_q <= 12'd1; fb_q <= '0;
			level_q <= 17'd43010; rev_q <= '0; dly_q <= '0; lpf_q <= 17'd65536;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_RATE:  rate_q  <= cfg_data[15:0];
				REG_DEPTH: depth_q <= cfg_data[11:0];
				REG_BASE:  base_q  <= cfg_data[11:0];
				REG_FB:    fb_q    <= cfg_data[15:0];
				REG_LEVEL: level_q <= cfg_data[16:0];
				REG_REV:   rev_q   <= cfg_data[16:0];
				REG_DLY:   dly_q   <= cfg_data[16:0];
				REG_LPF:   lpf_q   <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	// Tap address math.
	logic [24:0] lfo, lfo_r;
	logic [36:0] pl, pr;
	logic [21:0] dl, dr;
	function automatic logic [AW+7:0] tap_pos(input logic [21:0] d0, input logic [AW-1:0] wp);
		logic [21:0] d;
		logic [AW+8:0] p;
		d = d0;
		if (d < 22'd256) d = 22'd256;
		if (d > 22'(LINE_DEPTH * 256)) d = 22'(LINE_DEPTH * 256);
		p = {1'b0, wp, 8'd0} - (AW+9)'(d);
		if (p[AW+8]) p = p + (AW+9)'(LINE_DEPTH * 256);
		return p[AW+7:0];
	endfunction
	always_comb begin
		lfo = (phase_q >= 24'h800000) ? {1'b0, phase_q - 24'h800000} : {1'b0, 24'h800000 - phase_q};
		lfo = lfo << 1;
		lfo_r = 25'h1000000 - lfo;
		pl = 37'(lfo) * 37'(depth_q);
		pr = 37'(lfo_r) * 37'(depth_q);
		dl = 22'({base_q, 8'd0}) + 22'(pl >> 16);
		dr = 22'({base_q, 8'd0}) + 22'(pr >> 16);
	end

	// Shared multiplier: one product per cycle, registered.
	logic signed [25:0] ma;
	logic signed [17:0] mb;
	logic signed [43:0] mp_q;
	logic signed [43:0] acc_q;
	logic signed [47:0] mpx;
	assign mpx = 48'(mp_q);

	always_comb begin
		ma = '0; mb = '0;
		case (st_q)
			ST_IDLE: begin ma = 26'($signed(s_axis_tdata)) - 26'(lps_q); mb = 18'(lpf_q); end
			ST_RA1:  begin ma = 26'(rdl); mb = 18'(9'd256 - 9'(fl_q)); end
			ST_RB0:  begin ma = 26'(rdl); mb = 18'(fl_q); end
			ST_RB1:  begin ma = 26'(rdr); mb = 18'(fr_q); end
			ST_RB2:  begin ma = 26'(r0_q); mb = 18'(9'd256 - 9'(fr_q)); end
			ST_FB:   begin ma = 26'(tl_q); mb = 18'(fb_q); end
			ST_WR:   begin ma = 26'(tr_q); mb = 18'(fb_q); end
			ST_OUT1: begin ma = 26'(tl_q); mb = 18'(level_q); end
			ST_OUT2: begin ma = 26'(tr_q); mb = 18'(level_q); end
			default: ;
		endcase
	end

	logic signed [25:0] mono;
	assign mono = 26'((tl_q + tr_q) >>> 1);
	logic signed [43:0] prev_q;

	always_comb begin
		ram_we = 1'b0; wdl = '0; wdr = '0;
		ram_addr_l = wp_q; ram_addr_r = wp_q;
		case (st_q)
			ST_CLR: begin ram_we = 1'b1; ram_addr_l = clr_q; ram_addr_r = clr_q; end
			ST_RA0: begin ram_addr_l = xl0_q; ram_addr_r = xr0_q; end
			ST_RA1: begin ram_addr_l = xl0_q + 1'b1; ram_addr_r = xr0_q; end
			ST_RB0: begin ram_addr_r = xr0_q + 1'b1; end
			ST_WR:  begin ram_we = 1'b1; wdl = sat48(48'(x_q) + (mpx >>> 16)); end
			ST_OUT1: begin ram_we = 1'b1; wdr = sat48(48'(x_q) + (mpx >>> 16)); end
			default: ;
		endcase
	end

	logic wel, wer;
	assign wel = ram_we && (st_q != ST_OUT1);
	assign wer = ram_we && (st_q != ST_WR);
	logic signed [23:0] wdl_m, wdr_m;
	assign wdl_m = (st_q == ST_CLR) ? 24'sd0 : wdl;
	assign wdr_m = (st_q == ST_CLR) ? 24'sd0 : wdr;

	scd_line_ram u_left  (.clk(clk), .we(wel), .addr(ram_addr_l), .wdata(wdl_m), .rdata(rdl));
	scd_line_ram u_right (.clk(clk), .we(wer), .addr(ram_addr_r), .wdata(wdr_m), .rdata(rdr));

	assign s_axis_tready = (st_q == ST_IDLE);
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_q;

	logic [AW+7:0] pos_l, pos_r;
	assign pos_l = tap_pos(dl, wp_q);
	assign pos_r = tap_pos(dr, wp_q);

	// Read data arrive in the cycle after the address; the products follow in the cycle after that.
	always_ff @(posedge clk) begin
		mp_q <= 44'(ma * mb);
		prev_q <= mp_q;
		case (st_q)
			ST_IDLE: if (s_axis_tvalid && s_axis_tready) x_q <= $signed(s_axis_tdata);
			ST_LPF:  if (lpf_q < 17'd65536) x_q <= 24'(48'(lps_q) + (mpx >>> 16));
			ST_TAP: begin
				xl0_q <= pos_l[AW+7:8]; fl_q <= pos_l[7:0];
				xr0_q <= pos_r[AW+7:8]; fr_q <= pos_r[7:0];
			end
			ST_RB0:  r0_q <= rdr;
			ST_RB1:  acc_q <= prev_q + mp_q;
			ST_RB2:  tl_q <= 25'(acc_q >>> 8);
			ST_MAC:  tr_q <= 25'((mp_q + prev_q) >>> 8);
			default: ;
		endcase
		if (st_q == ST_OUT2) wl_q <= sat48(mpx >>> 16);
	end

	// Final output products: level left/right then two sends.
	logic [1:0] oc_q;
	logic signed [43:0] s_rev, s_dly;
	logic signed [47:0] pw;
	logic out_take, fin;
	assign out_take = m_axis_tvalid && m_axis_tready;
	assign fin = (st_q == ST_DONE) && (oc_q == 2'd3) && (!out_v_q || out_take);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLR; clr_q <= '0; wp_q <= '0; phase_q <= '0; lps_q <= '0;
			out_v_q <= 1'b0; oc_q <= '0;
		end else begin
			if (fin)
				out_v_q <= 1'b1;
			else if (out_take)
				out_v_q <= 1'b0;
			case (st_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(LINE_DEPTH - 1)) st_q <= ST_IDLE;
				end
				ST_IDLE: if (s_axis_tvalid && s_axis_tready) st_q <= ST_LPF;
				ST_LPF: begin
					if (lpf_q < 17'd65536) lps_q <= 24'(48'(lps_q) + (mpx >>> 16));
					st_q <= ST_TAP;
				end
				ST_TAP:  st_q <= ST_RA0;
				ST_RA0:  st_q <= ST_RA1;
				ST_RA1:  st_q <= ST_RB0;
				ST_RB0:  st_q <= ST_RB1;
				ST_RB1:  st_q <= ST_RB2;
				ST_RB2:  st_q <= ST_MAC;
				ST_MAC:  st_q <= ST_FB;
				ST_FB:   st_q <= ST_WR;
				ST_WR:   st_q <= ST_OUT1;
				ST_OUT1: st_q <= ST_OUT2;
				ST_OUT2: begin st_q <= ST_DONE; oc_q <= '0; end
				ST_DONE: begin
					if (oc_q != 2'd3)
						oc_q <= oc_q + 1'b1;
					// The last step waits here while the previous result is not taken.
					if (fin) begin
						st_q <= ST_IDLE;
						wp_q <= wp_q + 1'b1;
						phase_q <= phase_q + 24'(rate_q);
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Send products, one per DONE cycle, in a small side unit; the right-level result comes from the shared multiplier.
	logic signed [43:0] sp_q;
	logic signed [17:0] sg;
	logic signed [23:0] rs_q;
	assign sg = (oc_q == 2'd1) ? 18'(rev_q) : 18'(dly_q);
	assign s_rev = '0;
	assign s_dly = '0;
	assign pw = 48'(sp_q) + 48'(s_rev) + 48'(s_dly);
	always_ff @(posedge clk) begin
		sp_q <= 44'(mono * sg);
		if (st_q == ST_DONE) begin
			case (oc_q)
				2'd0: wr_q <= sat48(mpx >>> 16);
				2'd2: rs_q <= sat48(pw >>> 16);
				2'd3: if (fin) out_q <= {sat48(pw >>> 16), rs_q, wr_q, wl_q};
				default: ;
			endcase
		end
	end

	`SCD_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	`SCD_ASSERT_IMPL(a_no_accept_busy, clk, arst_n, !(s_axis_tready && st_q != ST_IDLE))
	`SCD_ASSERT_NEXT(a_out_stable, clk, arst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
endmodule
`default_nettype wire

FILE: hw/rtl/scd_line_ram.sv
// ----------------------------------------------------------------------------
// scd_line_ram
// One delay line: synchronous single port memory with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module scd_line_ram import scd_pkg::*; (
	input  wire logic                          clk,
	input  wire logic                          we,
	input  wire logic [AW-1:0]                 addr,
	input  wire logic signed [SAMPLE_BITS-1:0] wdata,
	output logic signed [SAMPLE_BITS-1:0]      rdata
);
	logic signed [SAMPLE_BITS-1:0] mem [LINE_DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire
